/* hw/rtl/skrl_pkg.sv */
// Soft-knee return limiter: shared types, constants and the control ROM.
// No dependencies; used by soft_knee_return_limiter.
package skrl_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned WetW    = 25;
  localparam int unsigned HeldW   = 40;
  localparam int unsigned GainW   = 32;
  localparam int unsigned RasterW = 7;
  localparam int unsigned StepW   = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned MulW    = 33;
  localparam int unsigned ProdW   = 66;
  localparam int unsigned DivCntW = 5;

  localparam logic [GainW-1:0]   UnityQ31    = 32'h8000_0000;
  localparam logic [HeldW-1:0]   HeldMax     = 40'h80_0000_0000;
  localparam logic [DivCntW-1:0] DivLastStep = 5'd31;

  // config register indexes
  localparam logic [CfgIdxW-1:0] CfgWetGain  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKnee     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRatio    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRelease  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDownRate = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgUpRate   = 3'd5;

  // program addresses
  localparam logic [StepW-1:0] S_IDLE     = 5'd0;
  localparam logic [StepW-1:0] S_MUL_L    = 5'd1;
  localparam logic [StepW-1:0] S_MUL_R    = 5'd2;
  localparam logic [StepW-1:0] S_WR_R     = 5'd3;
  localparam logic [StepW-1:0] S_PEAK     = 5'd4;
  localparam logic [StepW-1:0] S_BL_LO    = 5'd5;
  localparam logic [StepW-1:0] S_BL_HI    = 5'd6;
  localparam logic [StepW-1:0] S_BLEED    = 5'd7;
  localparam logic [StepW-1:0] S_KNEE     = 5'd8;
  localparam logic [StepW-1:0] S_EX_LO    = 5'd9;
  localparam logic [StepW-1:0] S_EX_HI    = 5'd10;
  localparam logic [StepW-1:0] S_DIV_INIT = 5'd11;
  localparam logic [StepW-1:0] S_DIV      = 5'd12;
  localparam logic [StepW-1:0] S_GLIDE    = 5'd13;
  localparam logic [StepW-1:0] S_GL_MUL   = 5'd14;
  localparam logic [StepW-1:0] S_GAIN     = 5'd15;
  localparam logic [StepW-1:0] S_OUT_L    = 5'd16;
  localparam logic [StepW-1:0] S_OUT_R    = 5'd17;
  localparam logic [StepW-1:0] S_EMIT     = 5'd18;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_L_WET,
    MUL_R_WET,
    MUL_DLO_REL,
    MUL_DHI_REL,
    MUL_DLO_RATIO,
    MUL_DHI_RATIO,
    MUL_DLO_RATE,
    MUL_L_GAIN,
    MUL_R_GAIN
  } mul_sel_e;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_NOP,
    OP_WR_L,
    OP_WR_R,
    OP_PEAK,
    OP_ACC_BL,
    OP_BLEED,
    OP_KNEE,
    OP_ACC_EX,
    OP_DIV_INIT,
    OP_DIV,
    OP_GLIDE,
    OP_GAIN,
    OP_WR_OL,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    C_NEXT,
    C_PEAK_UP,
    C_SKIP_TGT,
    C_DIV_MORE
  } cond_e;

  typedef struct packed {
    mul_sel_e         mul_sel;
    op_e              op;
    cond_e            cond;
    logic [StepW-1:0] target;
  } ctrl_t;

  function automatic ctrl_t ucode_rom(input logic [StepW-1:0] addr);
    ctrl_t w;
    w = '{mul_sel: MUL_NONE, op: OP_IDLE, cond: C_NEXT, target: S_IDLE};
    unique case (addr)
      S_IDLE:     w = '{MUL_NONE,      OP_IDLE,     C_NEXT,     S_IDLE};
      S_MUL_L:    w = '{MUL_L_WET,     OP_NOP,      C_NEXT,     S_IDLE};
      S_MUL_R:    w = '{MUL_R_WET,     OP_WR_L,     C_NEXT,     S_IDLE};
      S_WR_R:     w = '{MUL_NONE,      OP_WR_R,     C_NEXT,     S_IDLE};
      S_PEAK:     w = '{MUL_NONE,      OP_PEAK,     C_PEAK_UP,  S_KNEE};
      S_BL_LO:    w = '{MUL_DLO_REL,   OP_NOP,      C_NEXT,     S_IDLE};
      S_BL_HI:    w = '{MUL_DHI_REL,   OP_ACC_BL,   C_NEXT,     S_IDLE};
      S_BLEED:    w = '{MUL_NONE,      OP_BLEED,    C_NEXT,     S_IDLE};
      S_KNEE:     w = '{MUL_NONE,      OP_KNEE,     C_SKIP_TGT, S_GLIDE};
      S_EX_LO:    w = '{MUL_DLO_RATIO, OP_NOP,      C_NEXT,     S_IDLE};
      S_EX_HI:    w = '{MUL_DHI_RATIO, OP_ACC_EX,   C_NEXT,     S_IDLE};
      S_DIV_INIT: w = '{MUL_NONE,      OP_DIV_INIT, C_NEXT,     S_IDLE};
      S_DIV:      w = '{MUL_NONE,      OP_DIV,      C_DIV_MORE, S_DIV};
      S_GLIDE:    w = '{MUL_NONE,      OP_GLIDE,    C_NEXT,     S_IDLE};
      S_GL_MUL:   w = '{MUL_DLO_RATE,  OP_NOP,      C_NEXT,     S_IDLE};
      S_GAIN:     w = '{MUL_NONE,      OP_GAIN,     C_NEXT,     S_IDLE};
      S_OUT_L:    w = '{MUL_L_GAIN,    OP_NOP,      C_NEXT,     S_IDLE};
      S_OUT_R:    w = '{MUL_R_GAIN,    OP_WR_OL,    C_NEXT,     S_IDLE};
      S_EMIT:     w = '{MUL_NONE,      OP_EMIT,     C_NEXT,     S_IDLE};
      default:    w = '{MUL_NONE,      OP_IDLE,     C_NEXT,     S_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/soft_knee_return_limiter.sv */
// An accepted sample passes peak hold (instant rise, or bleed), the knee check, a gain target
// recompute when due (32-bit restoring divide), glide and output scaling before its result.
// A new sample is taken only once the previous result is emitted; a clear yields no result.
// The steps share one 33x33 multiplier; the divider makes one quotient bit per cycle.
// Reset (rst_ni low, async): registers to defaults, held peak 0, gain and target unity.
// Depends on skrl_pkg.
module soft_knee_return_limiter
  import skrl_pkg::*;
#(
  parameter int unsigned CONTROL_INTERVAL = 96
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // sample stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [47:0]          s_axis_tdata_i,   // [23:0] core_left, [47:24] core_right
  input  logic                 s_axis_tuser_i,   // command: 1 = clear limiter state
  // result stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [79:0]          m_axis_tdata_o,   // [23:0] out_left, [47:24] out_right,
                                                 // [79:48] gain_now
  // register writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] wet_q, ratio_q;
  logic [22:0] knee_q;
  logic [31:0] rel_q, down_rate_q, up_rate_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wet_q       <= 16'd26214;
      knee_q      <= 23'd471859;
      ratio_q     <= 16'd9830;
      rel_q       <= 32'd22369;
      down_rate_q <= 32'd89478;
      up_rate_q   <= 32'd14913;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgWetGain:  wet_q       <= cfg_data_i[15:0];
        CfgKnee:     knee_q      <= cfg_data_i[22:0];
        CfgRatio:    ratio_q     <= cfg_data_i[15:0];
        CfgRelease:  rel_q       <= cfg_data_i;
        CfgDownRate: down_rate_q <= cfg_data_i;
        CfgUpRate:   up_rate_q   <= cfg_data_i;
        default: ; // unknown index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: step counter addresses the control ROM
  // ---------------------------------------------------------------------------
  logic [StepW-1:0] step_q, step_d;
  ctrl_t            ctrl;

  assign ctrl = ucode_rom(step_q);

  // Control and limiter state
  logic [HeldW-1:0]   held_q, held_d;
  logic [GainW-1:0]   tgt_q, tgt_d;      // also the quotient shift register
  logic [GainW-1:0]   gain_q, gain_d;
  logic [RasterW-1:0] raster_q, raster_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic               down_q, down_d;
  logic               m_valid_q, m_valid_d;

  // Datapath payload
  logic signed [SampleW-1:0] core_l_q, core_r_q;
  logic signed [WetW-1:0]    wl_q, wr_q, wl_d, wr_d;
  logic [HeldW-1:0]          dif_q, dif_d;
  logic [31:0]               acc_q, acc_d;
  logic [HeldW:0]            rem_q, rem_d;
  logic [SampleW-1:0]        ol_q, ol_d;
  logic [79:0]               out_q, out_d;
  logic signed [ProdW-1:0]   prod_q;

  // ---------------------------------------------------------------------------
  // Shared multiplier, registered product
  // ---------------------------------------------------------------------------
  logic signed [MulW-1:0] mul_a, mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul_sel)
      MUL_L_WET: begin
        mul_a = MulW'(core_l_q);
        mul_b = $signed({17'd0, wet_q});
      end
      MUL_R_WET: begin
        mul_a = MulW'(core_r_q);
        mul_b = $signed({17'd0, wet_q});
      end
      MUL_DLO_REL: begin
        mul_a = $signed({1'b0, dif_q[31:0]});
        mul_b = $signed({1'b0, rel_q});
      end
      MUL_DHI_REL: begin
        mul_a = $signed({25'd0, dif_q[39:32]});
        mul_b = $signed({1'b0, rel_q});
      end
      MUL_DLO_RATIO: begin
        mul_a = $signed({1'b0, dif_q[31:0]});
        mul_b = $signed({17'd0, ratio_q});
      end
      MUL_DHI_RATIO: begin
        mul_a = $signed({25'd0, dif_q[39:32]});
        mul_b = $signed({17'd0, ratio_q});
      end
      MUL_DLO_RATE: begin
        mul_a = $signed({1'b0, dif_q[31:0]});
        mul_b = down_q ? $signed({1'b0, down_rate_q}) : $signed({1'b0, up_rate_q});
      end
      MUL_L_GAIN: begin
        mul_a = MulW'(wl_q);
        mul_b = $signed({1'b0, gain_q});
      end
      MUL_R_GAIN: begin
        mul_a = MulW'(wr_q);
        mul_b = $signed({1'b0, gain_q});
      end
      default: ;
    endcase
  end

  // product only captured on a multiply step, so a stalled emit keeps it
  always_ff @(posedge clk_i) begin
    if (ctrl.mul_sel != MUL_NONE) begin
      prod_q <= ProdW'(mul_a) * ProdW'(mul_b);
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------------
  function automatic logic [SampleW-1:0] sat24(input logic signed [34:0] v);
    logic ovf;
    ovf = (v[34:23] != {12{v[34]}});
    if (!ovf) return v[SampleW-1:0];
    return v[34] ? 24'h80_0000 : 24'h7F_FFFF;
  endfunction

  logic [SampleW-1:0] abs_l, abs_r, pk;
  logic [HeldW-1:0]   pk36, knee36, allowed, bleed;
  logic               peak_up, above_knee, skip_tgt, rem_ge, slot_free, in_acc, jump;
  logic [HeldW:0]     rem_sub;

  assign abs_l      = wl_q[WetW-1] ? SampleW'(-wl_q) : SampleW'(wl_q);
  assign abs_r      = wr_q[WetW-1] ? SampleW'(-wr_q) : SampleW'(wr_q);
  assign pk         = (abs_l > abs_r) ? abs_l : abs_r;
  assign pk36       = {pk, 16'd0};
  assign peak_up    = pk36 > held_q;
  assign knee36     = {1'b0, knee_q, 16'd0};
  assign above_knee = held_q > knee36;
  assign skip_tgt   = (raster_q != '0) || !above_knee;
  // knee + ratio * excess: high partial product in prod_q, low one >> 16 in acc_q
  assign allowed    = HeldW'({1'b0, knee36} + {1'b0, prod_q[23:0], 16'd0}
                             + {9'd0, acc_q});
  assign bleed      = HeldW'({1'b0, prod_q[39:0]} + {9'd0, acc_q});
  assign rem_ge     = rem_q >= {1'b0, held_q};
  assign rem_sub    = rem_ge ? (rem_q - {1'b0, held_q}) : rem_q;
  assign slot_free  = !m_valid_q || m_axis_tready_i;
  assign in_acc     = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = (step_q == S_IDLE);

  always_comb begin
    case (ctrl.cond)
      C_PEAK_UP:  jump = peak_up;
      C_SKIP_TGT: jump = skip_tgt;
      C_DIV_MORE: jump = (div_cnt_q != DivLastStep);
      default:    jump = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Next-state logic, one op per control word
  // ---------------------------------------------------------------------------
  always_comb begin
    step_d    = jump ? ctrl.target : step_q + 1'b1;
    held_d    = held_q;
    tgt_d     = tgt_q;
    gain_d    = gain_q;
    raster_d  = raster_q;
    div_cnt_d = div_cnt_q;
    down_d    = down_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    wl_d      = wl_q;
    wr_d      = wr_q;
    dif_d     = dif_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    ol_d      = ol_q;
    out_d     = out_q;

    unique case (ctrl.op)
      OP_IDLE: begin
        step_d = S_IDLE;
        if (in_acc) begin
          if (s_axis_tuser_i) begin
            held_d   = '0;
            tgt_d    = UnityQ31;
            gain_d   = UnityQ31;
            raster_d = '0;
          end else begin
            // raster reloads on a zero count, then counts down
            raster_d = ((raster_q == '0) ? RasterW'(CONTROL_INTERVAL) : raster_q) - 1'b1;
            step_d   = S_MUL_L;
          end
        end
      end
      OP_NOP: ;
      OP_WR_L: wl_d = prod_q[40:16];
      OP_WR_R: wr_d = prod_q[40:16];
      OP_PEAK: begin
        if (peak_up) held_d = pk36;
        else         dif_d  = held_q - pk36;
      end
      OP_ACC_BL: acc_d  = prod_q[63:32];
      OP_BLEED:  held_d = held_q - bleed;
      OP_KNEE: begin
        if (raster_q == '0) begin
          if (above_knee) dif_d = held_q - knee36;
          else            tgt_d = UnityQ31;
        end
      end
      OP_ACC_EX: acc_d = prod_q[47:16];
      OP_DIV_INIT: begin
        rem_d     = {1'b0, allowed};
        div_cnt_d = '0;
      end
      OP_DIV: begin
        tgt_d     = {tgt_q[GainW-2:0], rem_ge};
        rem_d     = {rem_sub[HeldW-1:0], 1'b0};
        div_cnt_d = div_cnt_q + 1'b1;
      end
      OP_GLIDE: begin
        down_d = tgt_q < gain_q;
        dif_d  = (tgt_q < gain_q) ? {8'd0, gain_q - tgt_q} : {8'd0, tgt_q - gain_q};
      end
      OP_GAIN: gain_d = down_q ? gain_q - prod_q[63:32] : gain_q + prod_q[63:32];
      OP_WR_OL: ol_d = sat24(prod_q[65:31]);
      OP_EMIT: begin
        if (slot_free) begin
          out_d     = {gain_q, sat24(prod_q[65:31]), ol_q};
          m_valid_d = 1'b1;
          step_d    = S_IDLE;
        end else begin
          step_d = S_EMIT;
        end
      end
      default: step_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= S_IDLE;
      held_q    <= '0;
      tgt_q     <= UnityQ31;
      gain_q    <= UnityQ31;
      raster_q  <= '0;
      div_cnt_q <= '0;
      down_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      step_q    <= step_d;
      held_q    <= held_d;
      tgt_q     <= tgt_d;
      gain_q    <= gain_d;
      raster_q  <= raster_d;
      div_cnt_q <= div_cnt_d;
      down_q    <= down_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      core_l_q <= s_axis_tdata_i[23:0];
      core_r_q <= s_axis_tdata_i[47:24];
    end
    wl_q  <= wl_d;
    wr_q  <= wr_d;
    dif_q <= dif_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    ol_q  <= ol_d;
    out_q <= out_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // glide never overshoots, so the gain stays at or below unity
  a_gain_le_unity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_q <= UnityQ31)
    else $error("gain above unity");

  // held peak is bounded by the largest widened sample magnitude
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= HeldMax)
    else $error("held peak out of range");

  // the divide loop is only entered through its setup step
  a_div_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_DIV) |-> ($past(step_q) == S_DIV_INIT || $past(step_q) == S_DIV))
    else $error("divider entered without setup");

  // an emit with a free slot presents a result and returns to idle
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_EMIT && slot_free) |=> (m_axis_tvalid_o && step_q == S_IDLE))
    else $error("result not emitted");

endmodule

/* tb/tb_soft_knee_return_limiter.sv */
// Self-checking testbench for soft_knee_return_limiter: stereo samples and clear items go in,
// and each limited result is checked against an in-bench fixed-point model of the limiter.
// Depends on skrl_pkg and the soft_knee_return_limiter RTL.
module tb_soft_knee_return_limiter
  import skrl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ControlInterval = 96;
  localparam int CycleLimit      = 1_000_000;
  localparam int SettleCycles    = 64;
  localparam int HoldOffCycles   = 600;
  localparam int MaxReports      = 10;

  localparam logic CmdSample = 1'b0;
  localparam logic CmdClear  = 1'b1;

  // indexes beyond the register map; writes to them must be dropped
  localparam logic [CfgIdxW-1:0] CfgSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpare7 = 3'd7;

  localparam logic [23:0] PosFull = 24'h7F_FFFF;
  localparam logic [23:0] NegFull = 24'h80_0000;

  // same layout as m_axis_tdata_o: gain_now on top, out_left at the bottom
  typedef struct packed {
    logic [31:0] gain;
    logic [23:0] right;
    logic [23:0] left;
  } wet_return_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready_o;
  logic [47:0]         s_axis_tdata = '0;   // [23:0] core_left, [47:24] core_right
  logic                s_axis_tuser = 1'b0; // command
  logic                m_axis_tvalid_o;
  logic                m_axis_tready = 1'b0;
  logic [79:0]         m_axis_tdata_o;      // [23:0] out_left, [47:24] out_right,
                                            // [79:48] gain_now
  logic                cfg_valid = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [31:0]         cfg_data = '0;

  // register copies
  logic [15:0] wet_gain_r;
  logic [22:0] knee_r;
  logic [15:0] ratio_r;
  logic [31:0] release_r;
  logic [31:0] down_rate_r;
  logic [31:0] up_rate_r;

  // limiter state copies
  logic [39:0] held_peak;
  logic [31:0] gain_tgt;
  logic [31:0] gain_cur;
  logic [6:0]  raster;

  wet_return_t pending_returns[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;

  soft_knee_return_limiter #(
    .CONTROL_INTERVAL(ControlInterval)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Limiter model
  // ---------------------------------------------------------------------------
  function automatic void clear_limiter();
    held_peak = '0;
    gain_tgt  = UnityQ31;
    gain_cur  = UnityQ31;
    raster    = '0;
  endfunction

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    case (idx)
      CfgWetGain:  wet_gain_r  = data[15:0];
      CfgKnee:     knee_r      = data[22:0];
      CfgRatio:    ratio_r     = data[15:0];
      CfgRelease:  release_r   = data;
      CfgDownRate: down_rate_r = data;
      CfgUpRate:   up_rate_r   = data;
      default: ;
    endcase
  endfunction

  // Advances the model by one item; returns 1 when the item yields a result.
  function automatic bit limit_return(input logic cmd, input logic [23:0] left,
                                      input logic [23:0] right, output wet_return_t res);
    longint      wl, wr, al, ar, pk, oleft, oright;
    logic [39:0] pk36, knee36, allowed;
    logic [79:0] bleed;
    logic [63:0] excess, glide, rem, q;
    res = '0;
    if (cmd == CmdClear) begin
      clear_limiter();
      return 1'b0;
    end

    if (raster == 0) raster = 7'(ControlInterval);
    raster = raster - 7'd1;

    // wet trim, floor rounding
    wl = (longint'(signed'(left))  * longint'(wet_gain_r)) >>> 16;
    wr = (longint'(signed'(right)) * longint'(wet_gain_r)) >>> 16;
    al = (wl < 0) ? -wl : wl;
    ar = (wr < 0) ? -wr : wr;
    pk = (al > ar) ? al : ar;
    pk36 = 40'(pk) << 16;

    // peak hold: instant attack, proportional bleed
    if (pk36 > held_peak) begin
      held_peak = pk36;
    end else begin
      bleed = 80'(held_peak - pk36) * 80'(release_r);
      held_peak = held_peak - 40'(bleed >> 32);
    end

    // control raster: new target once per interval
    if (raster == 0) begin
      knee36 = 40'(knee_r) << 16;
      if (held_peak > knee36) begin
        excess  = 64'(held_peak - knee36) * 64'(ratio_r);
        allowed = knee36 + 40'(excess >> 16);
        q   = '0;
        rem = 64'(allowed);
        if (rem >= 64'(held_peak)) begin
          rem = rem - 64'(held_peak);
          q = 64'd1;
        end
        for (int i = 0; i < 31; i++) begin
          rem = rem << 1;
          q   = q << 1;
          if (rem >= 64'(held_peak)) begin
            rem = rem - 64'(held_peak);
            q = q | 64'd1;
          end
        end
        gain_tgt = q[31:0];
      end else begin
        gain_tgt = UnityQ31;
      end
    end

    // glide never overshoots the target
    if (gain_tgt < gain_cur) begin
      glide = 64'(gain_cur - gain_tgt) * 64'(down_rate_r);
      gain_cur = gain_cur - glide[63:32];
    end else begin
      glide = 64'(gain_tgt - gain_cur) * 64'(up_rate_r);
      gain_cur = gain_cur + glide[63:32];
    end

    oleft  = (wl * longint'(gain_cur)) >>> 31;
    oright = (wr * longint'(gain_cur)) >>> 31;
    if (oleft > 8388607) oleft = 8388607;
    else if (oleft < -8388608) oleft = -8388608;
    if (oright > 8388607) oright = 8388607;
    else if (oright < -8388608) oright = -8388608;
    res.left  = oleft[23:0];
    res.right = oright[23:0];
    res.gain  = gain_cur;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls, one long hold-off on request, field checks
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldOffCycles;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic void report_mismatch(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MaxReports)
      $display("mismatch on %s at cycle %0d: expected %h, actual %h",
               field, cycle_count, want, got);
  endfunction

  always @(posedge clk_i) begin
    wet_return_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready) begin
      got = m_axis_tdata_o;
      if (pending_returns.size() == 0) begin
        report_mismatch("unexpected result", '0, got.gain);
      end else begin
        want = pending_returns.pop_front();
        if (got.left !== want.left)   report_mismatch("out_left", want.left, got.left);
        if (got.right !== want.right) report_mismatch("out_right", want.right, got.right);
        if (got.gain !== want.gain)   report_mismatch("gain_now", want.gain, got.gain);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers; all called and returning at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic cmd, input logic [23:0] left, input logic [23:0] right);
    wet_return_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {right, left};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready_o);
    if (limit_return(cmd, left, right, res)) pending_returns.push_back(res);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    apply_reg(idx, data);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Wait for every pending result, then for the block to finish any clear item.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_returns.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic load_settings(input logic [31:0] wet, input logic [31:0] knee,
                               input logic [31:0] ratio, input logic [31:0] rel,
                               input logic [31:0] down, input logic [31:0] up);
    settle();
    write_reg(CfgWetGain, wet);
    write_reg(CfgKnee, knee);
    write_reg(CfgRatio, ratio);
    write_reg(CfgRelease, rel);
    write_reg(CfgDownRate, down);
    write_reg(CfgUpRate, up);
  endtask

  task automatic load_random_settings();
    load_settings($urandom_range(0, 65535),
                  $urandom_range(0, 23'h7F_FFFF) >> $urandom_range(0, 5),
                  $urandom_range(0, 65535),
                  $urandom >> $urandom_range(0, 24),
                  $urandom >> $urandom_range(0, 24),
                  $urandom >> $urandom_range(0, 24));
  endtask

  // Mix of full-range, quiet, near-clip and attenuated sample values.
  function automatic logic [23:0] draw_sample();
    logic signed [23:0] v;
    v = 24'($urandom);
    case ($urandom_range(0, 3))
      0: ;
      1: v = v >>> 12;
      2: v = v[23] ? NegFull + 24'($urandom_range(0, 255)) : PosFull - 24'($urandom_range(0, 255));
      default: v = v >>> $urandom_range(1, 8);
    endcase
    return v;
  endfunction

  // Clears are rare so that runs reach many target updates.
  task automatic run_items(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 199) == 0) send_item(CmdClear, 24'($urandom), 24'($urandom));
      else send_item(CmdSample, draw_sample(), draw_sample());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    send_item(CmdSample, 24'h00_0000, 24'h00_0000);
    send_item(CmdSample, PosFull, PosFull);
    send_item(CmdSample, NegFull, NegFull);
    send_item(CmdSample, PosFull, NegFull);
    send_item(CmdSample, NegFull, PosFull);
    send_item(CmdSample, 24'h00_0001, 24'hFF_FFFF);
    send_item(CmdSample, 24'hFF_FFFF, 24'h00_0001);
    send_item(CmdClear,  24'hFF_FFFF, 24'hFF_FFFF);   // payload ignored
    send_item(CmdSample, 24'h40_0000, 24'hC0_0000);
    send_item(CmdClear,  24'h00_0000, 24'h00_0000);
    send_item(CmdClear,  24'h55_AAAA, 24'hAA_5555);   // back-to-back clears
    send_item(CmdSample, 24'h12_3456, 24'h65_4321);
    send_item(CmdSample, NegFull, 24'h00_0000);
    send_item(CmdSample, 24'h00_0000, PosFull);
    send_item(CmdSample, 24'h07_3333, 24'hF8_CCCD);  // raw magnitude equal to the default knee
    send_item(CmdSample, 24'h00_0000, 24'h00_0000);
    settle();
  endtask

  // Loud then quiet stretches across target updates, above and below the knee.
  task automatic test_control_raster();
    send_item(CmdClear, 24'($urandom), 24'($urandom));
    for (int i = 0; i < 2 * ControlInterval; i++)
      send_item(CmdSample, 24'($urandom) | 24'h60_0000, draw_sample());
    for (int i = 0; i < ControlInterval + 10; i++)
      send_item(CmdSample, 24'($urandom_range(0, 4095)), 24'(-$urandom_range(0, 4095)));
    settle();
  endtask

  task automatic test_register_extremes();
    // every field at its top, upper data bits set to check masking
    load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_reg(CfgSpare6, $urandom);
    write_reg(CfgSpare7, $urandom);
    run_items(100);
    // knee at zero: every nonzero peak is above it
    load_settings(32'h0000_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    run_items(120);
    load_settings(32'h0, 32'h0, 32'hFFFF, 32'h0, 32'h0, 32'h0);
    run_items(30);
    load_settings(32'hFFFF, 32'h1000, 32'h4000, 32'h0, 32'h0100_0000, 32'h0001_0000);
    run_items(100);
    settle();
  endtask

  task automatic test_idle_modes();
    int send_pct[4] = '{0, 67, 0, 6};
    int stall_pct[4] = '{0, 0, 67, 6};
    for (int m = 0; m < 4; m++) begin
      load_random_settings();
      send_idle_pct  = send_pct[m];
      recv_stall_pct = stall_pct[m];
      run_items(265);
      settle();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Receiver holds off for a long stretch while items keep coming.
  task automatic test_output_holdoff();
    load_random_settings();
    hold_req = 1'b1;
    run_items(60);
    recv_stall_pct = 30;
    run_items(120);
    recv_stall_pct = 0;
    settle();
  endtask

  initial begin
    wet_gain_r  = 16'd26214;
    knee_r      = 23'd471859;
    ratio_r     = 16'd9830;
    release_r   = 32'd22369;
    down_rate_r = 32'd89478;
    up_rate_r   = 32'd14913;
    clear_limiter();

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_control_raster();
    test_register_extremes();
    test_idle_modes();
    test_output_holdoff();

    if (mismatch_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
